// ----- src/psh_pkg.sv -----
// Package for the pair/sync handshake controller.
// Holds shared constants, codes and structs; no dependencies.
`timescale 1ns / 1ps

package psh_pkg;

	localparam int AddrBits = 48;
	localparam int CntBits = 16;
	localparam int PhaseBits = 5;
	localparam int PaddrBits = 5;

	// last resend phase value; the phase then wraps to zero
	localparam logic [PhaseBits-1:0] ResendLast = 5'd19;

	typedef enum logic [2:0] {
		MODE_BLANK    = 3'd0,
		MODE_PAIRING  = 3'd1,
		MODE_UNSYNCED = 3'd2,
		MODE_SYNCING  = 3'd3,
		MODE_SYNCED   = 3'd4
	} mode_t;

	// received message kinds
	localparam logic [2:0] KindPairReq  = 3'd0;
	localparam logic [2:0] KindSyncReq  = 3'd1;
	localparam logic [2:0] KindPairEcho = 3'd2;
	localparam logic [2:0] KindSyncEcho = 3'd3;

	// transmit kinds
	localparam logic [2:0] TxNone     = 3'd0;
	localparam logic [2:0] TxPairReq  = 3'd1;
	localparam logic [2:0] TxSyncReq  = 3'd2;
	localparam logic [2:0] TxPairEcho = 3'd3;
	localparam logic [2:0] TxSyncEcho = 3'd4;

	// radio commands
	localparam logic [1:0] RadioNone   = 2'd0;
	localparam logic [1:0] RadioBcast  = 2'd1;
	localparam logic [1:0] RadioDirect = 2'd2;
	localparam logic [1:0] RadioOff    = 2'd3;

	// register indexes (paddr[4:2])
	localparam logic [2:0] RegRoleLeader = 3'd0;
	localparam logic [2:0] RegLongPress  = 3'd1;
	localparam logic [2:0] RegVLongPress = 3'd2;
	localparam logic [2:0] RegPairTo     = 3'd3;
	localparam logic [2:0] RegLSyncTo    = 3'd4;
	localparam logic [2:0] RegFSyncTo    = 3'd5;

	typedef struct packed {
		logic                role_leader;
		logic [CntBits-1:0]  long_press_ms;
		logic [CntBits-1:0]  very_long_press_ms;
		logic [CntBits-1:0]  pair_timeout_ticks;
		logic [CntBits-1:0]  leader_sync_timeout_ticks;
		logic [CntBits-1:0]  follower_sync_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic                button_pressed;
		logic [15:0]         press_ms;
		logic                msg_arrived;
		logic [2:0]          msg_kind;
		logic [AddrBits-1:0] msg_source;
		logic                echo_send_ok;
	} item_t;

	typedef struct packed {
		logic [2:0]          mode;
		logic                in_sync;
		logic [AddrBits-1:0] partner_address;
		logic [2:0]          tx_kind;
		logic [1:0]          radio_cmd;
		logic                sync_mark;
		logic                save_request;
		logic                shutdown_request;
		logic                protocol_error;
	} result_t;

endpackage

// ----- src/psh_cfg.sv -----
// Configuration register file with APB-style access.
// Depends on psh_pkg for the register indexes and cfg_t.
`timescale 1ns / 1ps

module psh_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psh_pkg::PaddrBits-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output psh_pkg::cfg_t                  cfg
);

	psh_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.role_leader                 <= 1'b0;
			cfg_q.long_press_ms               <= 16'd3000;
			cfg_q.very_long_press_ms          <= 16'd12000;
			cfg_q.pair_timeout_ticks          <= 16'd600;
			cfg_q.leader_sync_timeout_ticks   <= 16'd600;
			cfg_q.follower_sync_timeout_ticks <= 16'd1200;
		end else if (wr_en) begin
			unique case (reg_idx)
				psh_pkg::RegRoleLeader: cfg_q.role_leader                 <= pwdata[0];
				psh_pkg::RegLongPress:  cfg_q.long_press_ms               <= pwdata[15:0];
				psh_pkg::RegVLongPress: cfg_q.very_long_press_ms          <= pwdata[15:0];
				psh_pkg::RegPairTo:     cfg_q.pair_timeout_ticks          <= pwdata[15:0];
				psh_pkg::RegLSyncTo:    cfg_q.leader_sync_timeout_ticks   <= pwdata[15:0];
				psh_pkg::RegFSyncTo:    cfg_q.follower_sync_timeout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			psh_pkg::RegRoleLeader: prdata = {31'd0, cfg_q.role_leader};
			psh_pkg::RegLongPress:  prdata = {16'd0, cfg_q.long_press_ms};
			psh_pkg::RegVLongPress: prdata = {16'd0, cfg_q.very_long_press_ms};
			psh_pkg::RegPairTo:     prdata = {16'd0, cfg_q.pair_timeout_ticks};
			psh_pkg::RegLSyncTo:    prdata = {16'd0, cfg_q.leader_sync_timeout_ticks};
			psh_pkg::RegFSyncTo:    prdata = {16'd0, cfg_q.follower_sync_timeout_ticks};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/psh_core.sv -----
// Link state registers and the per-tick decision logic.
// Depends on psh_pkg; state advances when en is high.
`timescale 1ns / 1ps

module psh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  psh_pkg::cfg_t     cfg,
	input  psh_pkg::item_t    item,
	output psh_pkg::result_t  result
);

	psh_pkg::mode_t                  mode_q, n_mode;
	logic                            sync_q, n_sync;
	logic [psh_pkg::AddrBits-1:0]    partner_q, n_partner;
	logic [psh_pkg::CntBits-1:0]     retry_q, n_retry, inc_retry;
	logic [psh_pkg::PhaseBits-1:0]   phase_q, n_phase, inc_phase;
	logic                            ractive_q, n_ractive;
	logic                            mfull_q, n_mfull;
	logic [2:0]                      mkind_q, n_mkind;
	logic [psh_pkg::AddrBits-1:0]    msrc_q, n_msrc;
	logic                            halted_q, n_halted;

	logic [2:0] o_tx;
	logic [1:0] o_radio;
	logic       o_mark, o_save, o_shut, o_err;
	logic       do_shut;
	logic       paired_now;

	// saturating retry count; phase tracks retry_count mod 20
	always_comb begin
		if (retry_q == {psh_pkg::CntBits{1'b1}}) begin
			inc_retry = retry_q;
			inc_phase = phase_q;
		end else begin
			inc_retry = retry_q + 1'b1;
			inc_phase = (phase_q == psh_pkg::ResendLast) ? '0 : phase_q + 1'b1;
		end
	end

	always_comb begin
		n_mode     = mode_q;
		n_sync     = sync_q;
		n_partner  = partner_q;
		n_retry    = retry_q;
		n_phase    = phase_q;
		n_ractive  = ractive_q;
		n_mfull    = mfull_q;
		n_mkind    = mkind_q;
		n_msrc     = msrc_q;
		n_halted   = halted_q;
		o_tx       = psh_pkg::TxNone;
		o_radio    = psh_pkg::RadioNone;
		o_mark     = 1'b0;
		o_save     = 1'b0;
		o_shut     = 1'b0;
		o_err      = 1'b0;
		do_shut    = 1'b0;
		paired_now = 1'b0;

		if (!halted_q) begin
			if (item.msg_arrived && !mfull_q) begin
				n_mfull = 1'b1;
				n_mkind = item.msg_kind;
				n_msrc  = item.msg_source;
			end

			if (item.button_pressed && item.press_ms > cfg.very_long_press_ms) begin
				// factory reset
				n_mode    = psh_pkg::MODE_BLANK;
				n_sync    = 1'b0;
				n_partner = '0;
				do_shut   = 1'b1;
			end else if (item.button_pressed
					&& item.press_ms <= cfg.long_press_ms) begin
				do_shut = 1'b1;
			end else if (item.button_pressed && mode_q == psh_pkg::MODE_SYNCED) begin
				do_shut = 1'b1;
			end else if (item.button_pressed && mode_q == psh_pkg::MODE_SYNCING) begin
				// re-pair; retry count deliberately left as is
				n_partner = '0;
				n_mode    = psh_pkg::MODE_PAIRING;
				n_sync    = 1'b0;
				o_radio   = psh_pkg::RadioBcast;
				n_ractive = 1'b1;
				if (cfg.role_leader)
					o_tx = psh_pkg::TxPairReq;
			end else if (cfg.role_leader) begin
				unique case (mode_q)
					psh_pkg::MODE_BLANK: begin
						n_retry   = '0;
						n_phase   = '0;
						n_mode    = psh_pkg::MODE_PAIRING;
						n_sync    = 1'b0;
						o_radio   = psh_pkg::RadioBcast;
						n_ractive = 1'b1;
						o_tx      = psh_pkg::TxPairReq;
					end
					psh_pkg::MODE_PAIRING: begin
						n_retry = inc_retry;
						n_phase = inc_phase;
						if (n_mfull) begin
							n_mfull = 1'b0;
							if (n_mkind != psh_pkg::KindPairEcho) begin
								o_err = 1'b1;
							end else begin
								n_partner = n_msrc;
								n_sync    = 1'b1;
								n_mode    = psh_pkg::MODE_SYNCED;
								o_mark    = 1'b1;
								o_radio   = psh_pkg::RadioOff;
								n_ractive = 1'b0;
								o_save    = 1'b1;
							end
						end else if (n_retry > cfg.pair_timeout_ticks) begin
							n_mode  = psh_pkg::MODE_BLANK;
							do_shut = 1'b1;
						end else if (n_phase == '0) begin
							if (!n_ractive) begin
								o_radio   = psh_pkg::RadioBcast;
								n_ractive = 1'b1;
							end
							o_tx = psh_pkg::TxPairReq;
						end
					end
					psh_pkg::MODE_UNSYNCED: begin
						n_mode    = psh_pkg::MODE_SYNCING;
						n_sync    = 1'b0;
						o_radio   = psh_pkg::RadioDirect;
						n_ractive = 1'b1;
						o_tx      = psh_pkg::TxSyncReq;
						n_retry   = '0;
						n_phase   = '0;
					end
					psh_pkg::MODE_SYNCING: begin
						n_retry = inc_retry;
						n_phase = inc_phase;
						if (n_mfull) begin
							n_mfull = 1'b0;
							if (n_mkind != psh_pkg::KindSyncEcho || n_msrc != partner_q) begin
								o_err = 1'b1;
							end else begin
								n_sync    = 1'b1;
								n_mode    = psh_pkg::MODE_SYNCED;
								o_mark    = 1'b1;
								o_radio   = psh_pkg::RadioOff;
								n_ractive = 1'b0;
							end
						end else if (n_retry > cfg.leader_sync_timeout_ticks) begin
							n_mode  = psh_pkg::MODE_UNSYNCED;
							do_shut = 1'b1;
						end else if (n_phase == '0) begin
							o_tx = psh_pkg::TxSyncReq;
						end
					end
					default: ;
				endcase
			end else begin
				unique case (mode_q)
					psh_pkg::MODE_BLANK: begin
						n_mode    = psh_pkg::MODE_PAIRING;
						n_sync    = 1'b0;
						o_radio   = psh_pkg::RadioBcast;
						n_ractive = 1'b1;
						n_retry   = '0;
						n_phase   = '0;
					end
					psh_pkg::MODE_PAIRING: begin
						n_retry = inc_retry;
						n_phase = inc_phase;
						if (n_mfull) begin
							n_mfull = 1'b0;
							if (n_mkind != psh_pkg::KindPairReq) begin
								o_err = 1'b1;
							end else begin
								n_partner = n_msrc;
								o_tx      = psh_pkg::TxPairEcho;
								if (item.echo_send_ok) begin
									n_sync     = 1'b1;
									n_mode     = psh_pkg::MODE_SYNCED;
									o_mark     = 1'b1;
									o_radio    = psh_pkg::RadioOff;
									n_ractive  = 1'b0;
									o_save     = 1'b1;
									paired_now = 1'b1;
								end
							end
						end
						if (!n_ractive && !paired_now) begin
							o_radio   = psh_pkg::RadioDirect;
							n_ractive = 1'b1;
						end
						// timeout still wins over a pair in the same tick
						if (n_retry > cfg.pair_timeout_ticks) begin
							n_mode  = psh_pkg::MODE_BLANK;
							do_shut = 1'b1;
						end
					end
					psh_pkg::MODE_UNSYNCED: begin
						n_mode    = psh_pkg::MODE_SYNCING;
						n_sync    = 1'b0;
						o_radio   = psh_pkg::RadioDirect;
						n_ractive = 1'b1;
						n_retry   = '0;
						n_phase   = '0;
					end
					psh_pkg::MODE_SYNCING: begin
						n_retry = inc_retry;
						n_phase = inc_phase;
						if (n_mfull) begin
							n_mfull = 1'b0;
							if (n_mkind != psh_pkg::KindSyncReq || n_msrc != partner_q) begin
								o_err = 1'b1;
							end else begin
								o_tx = psh_pkg::TxSyncEcho;
								if (item.echo_send_ok) begin
									n_sync    = 1'b1;
									n_mode    = psh_pkg::MODE_SYNCED;
									o_mark    = 1'b1;
									o_radio   = psh_pkg::RadioOff;
									n_ractive = 1'b0;
								end
							end
						end
						if (n_retry > cfg.follower_sync_timeout_ticks) begin
							n_mode  = psh_pkg::MODE_UNSYNCED;
							do_shut = 1'b1;
						end
					end
					default: ;
				endcase
			end

			// shutdown is always the last action of a tick
			if (do_shut) begin
				n_sync = 1'b0;
				if (n_mode == psh_pkg::MODE_PAIRING)
					n_mode = psh_pkg::MODE_BLANK;
				if (n_mode == psh_pkg::MODE_SYNCING || n_mode == psh_pkg::MODE_SYNCED)
					n_mode = psh_pkg::MODE_UNSYNCED;
				o_save    = 1'b1;
				o_radio   = psh_pkg::RadioOff;
				n_ractive = 1'b0;
				o_shut    = 1'b1;
				n_halted  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= psh_pkg::MODE_BLANK;
			sync_q    <= 1'b0;
			partner_q <= '0;
			retry_q   <= '0;
			phase_q   <= '0;
			ractive_q <= 1'b0;
			mfull_q   <= 1'b0;
			mkind_q   <= '0;
			msrc_q    <= '0;
			halted_q  <= 1'b0;
		end else if (en) begin
			mode_q    <= n_mode;
			sync_q    <= n_sync;
			partner_q <= n_partner;
			retry_q   <= n_retry;
			phase_q   <= n_phase;
			ractive_q <= n_ractive;
			mfull_q   <= n_mfull;
			mkind_q   <= n_mkind;
			msrc_q    <= n_msrc;
			halted_q  <= n_halted;
		end
	end

	assign result.mode             = n_mode;
	assign result.in_sync          = n_sync;
	assign result.partner_address  = n_partner;
	assign result.tx_kind          = o_tx;
	assign result.radio_cmd        = o_radio;
	assign result.sync_mark        = o_mark;
	assign result.save_request     = o_save;
	assign result.shutdown_request = o_shut;
	assign result.protocol_error   = o_err;

endmodule

// ----- src/pairing_sync_handshake_controller.sv -----
// Channel  | Dir | Handshake            | Content
// s_*      | in  | s_tvalid / s_tready  | one tick: press, message, echo status
// m_*      | out | m_tvalid / m_tready  | one result per tick
// APB      | in  | psel & penable       | six configuration registers
//
// One tick per clock while m_tready is high; via input register, then result register.
// The input register feeds psh_core, whose state registers step when the tick moves
// into the result register. A stalled result holds the result register; the input
// register takes one more tick and then s_tready drops. Reset clears all link state;
// after a shutdown the block only echoes mode and partner until the next reset.
// Top level; depends on psh_pkg, psh_cfg and psh_core.
`timescale 1ns / 1ps

module pairing_sync_handshake_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_tdata: button_pressed[0], press_ms[16:1], msg_arrived[17],
	//          msg_source[65:18], echo_send_ok[66], zero fill [71:67]
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [71:0]                    s_tdata,
	// s_tuser: msg_kind[2:0]
	input  logic [2:0]                     s_tuser,
	// m_tdata: mode[2:0], in_sync[3], partner_address[51:4], tx_kind[54:52],
	//          radio_cmd[56:55], sync_mark[57], save_request[58],
	//          shutdown_request[59], protocol_error[60], zero fill [63:61]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psh_pkg::PaddrBits-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	psh_pkg::cfg_t    cfg;
	psh_pkg::item_t   item_s1;
	psh_pkg::result_t res_c;
	psh_pkg::result_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;
	logic             in_take;

	psh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (res_c)
	);

	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign in_take  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.button_pressed <= s_tdata[0];
			item_s1.press_ms       <= s_tdata[16:1];
			item_s1.msg_arrived    <= s_tdata[17];
			item_s1.msg_kind       <= s_tuser;
			item_s1.msg_source     <= s_tdata[65:18];
			item_s1.echo_send_ok   <= s_tdata[66];
		end
		if (advance)
			res_q <= res_c;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, res_q.protocol_error, res_q.shutdown_request,
		res_q.save_request, res_q.sync_mark, res_q.radio_cmd, res_q.tx_kind,
		res_q.partner_address, res_q.in_sync, res_q.mode};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for pairing_sync_handshake_controller: stream ticks in, results out.
// Predicts each result from its own link state model and compares every field.
// Depends on psh_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
	import psh_pkg::*;

	localparam int ResendTicks = 20;
	localparam int StallLimit = 1000;
	localparam int RandomPhases = 6;
	localparam int PhaseTicks = 135;
	localparam logic [2:0] KindOther = 3'd4;
	localparam logic [2:0] KindMax = 3'd7;

	typedef struct {
		mode_t               mode;
		logic                synced;
		logic [AddrBits-1:0] partner;
		logic [15:0]         retry;
		logic                radio_live;
		logic                mb_full;
		logic [2:0]          mb_kind;
		logic [AddrBits-1:0] mb_src;
		logic                halted;
	} link_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PaddrBits-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	item_t cur_item = '0;
	item_t ticks_queued[$];
	result_t due_results[$];
	link_state_t plan_state;   // runs ahead while requests are generated
	link_state_t link_state;   // steps on each accepted request
	cfg_t cfg_now = '{1'b0, 16'd3000, 16'd12000, 16'd600, 16'd600, 16'd1200};
	logic s_taken = 1'b0;
	int s_gap = 0;
	int m_gap = 0;
	int idle_ticks = 0;
	int errors = 0;
	bit idle_on = 1'b1;

	always #5 clk = ~clk;

	pairing_sync_handshake_controller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	assign s_tdata = {5'b0, cur_item.echo_send_ok, cur_item.msg_source, cur_item.msg_arrived,
		cur_item.press_ms, cur_item.button_pressed};
	assign s_tuser = cur_item.msg_kind;

	function automatic link_state_t reset_state();
		link_state_t st;
		st.mode = MODE_BLANK;
		st.synced = 1'b0;
		st.partner = '0;
		st.retry = '0;
		st.radio_live = 1'b0;
		st.mb_full = 1'b0;
		st.mb_kind = '0;
		st.mb_src = '0;
		st.halted = 1'b0;
		return st;
	endfunction

	function automatic void set_radio(inout link_state_t st, inout result_t r, input logic [1:0] cmd);
		r.radio_cmd = cmd;
		st.radio_live = (cmd != RadioOff);
	endfunction

	function automatic void go_halt(inout link_state_t st, inout result_t r);
		st.synced = 1'b0;
		if (st.mode == MODE_PAIRING) begin
			st.mode = MODE_BLANK;
		end
		if (st.mode == MODE_SYNCING || st.mode == MODE_SYNCED) begin
			st.mode = MODE_UNSYNCED;
		end
		r.save_request = 1'b1;
		set_radio(st, r, RadioOff);
		r.shutdown_request = 1'b1;
		st.halted = 1'b1;
	endfunction

	function automatic void go_pairing(inout link_state_t st, inout result_t r, input logic leader);
		st.mode = MODE_PAIRING;
		st.synced = 1'b0;
		set_radio(st, r, RadioBcast);
		if (leader) begin
			r.tx_kind = TxPairReq;
		end
	endfunction

	function automatic void go_synced(inout link_state_t st, inout result_t r);
		st.synced = 1'b1;
		st.mode = MODE_SYNCED;
		r.sync_mark = 1'b1;
		set_radio(st, r, RadioOff);
	endfunction

	function automatic result_t step_link(inout link_state_t st, input cfg_t c, input item_t it);
		result_t r;
		logic [AddrBits-1:0] src;
		logic paired_now;
		r = '0;
		paired_now = 1'b0;
		if (!st.halted) begin
			// one-slot mailbox: a message arriving while one is held is lost
			if (it.msg_arrived && !st.mb_full) begin
				st.mb_full = 1'b1;
				st.mb_kind = it.msg_kind;
				st.mb_src = it.msg_source;
			end
			src = st.mb_src;
			if (it.button_pressed && it.press_ms > c.very_long_press_ms) begin
				// factory reset forgets the partner
				st.mode = MODE_BLANK;
				st.synced = 1'b0;
				st.partner = '0;
				go_halt(st, r);
			end else if (it.button_pressed &&
				(it.press_ms <= c.long_press_ms || st.mode == MODE_SYNCED)) begin
				go_halt(st, r);
			end else if (it.button_pressed && st.mode == MODE_SYNCING) begin
				// re-pair; retry count is left as it is
				st.partner = '0;
				go_pairing(st, r, c.role_leader);
			end else begin
				if ((st.mode == MODE_PAIRING || st.mode == MODE_SYNCING) && st.retry != 16'hFFFF) begin
					st.retry++;
				end
				case (st.mode)
					MODE_BLANK: begin
						st.retry = '0;
						go_pairing(st, r, c.role_leader);
					end
					MODE_UNSYNCED: begin
						st.mode = MODE_SYNCING;
						st.synced = 1'b0;
						set_radio(st, r, RadioDirect);
						if (c.role_leader) begin
							r.tx_kind = TxSyncReq;
						end
						st.retry = '0;
					end
					MODE_PAIRING: if (c.role_leader) begin
						if (st.mb_full) begin
							st.mb_full = 1'b0;
							if (st.mb_kind != KindPairEcho) begin
								r.protocol_error = 1'b1;
							end else begin
								st.partner = src;
								go_synced(st, r);
								r.save_request = 1'b1;
							end
						end else if (st.retry > c.pair_timeout_ticks) begin
							st.mode = MODE_BLANK;
							go_halt(st, r);
						end else if (st.retry % ResendTicks == 0) begin
							if (!st.radio_live) begin
								set_radio(st, r, RadioBcast);
							end
							r.tx_kind = TxPairReq;
						end
					end else begin
						if (st.mb_full) begin
							st.mb_full = 1'b0;
							if (st.mb_kind != KindPairReq) begin
								r.protocol_error = 1'b1;
							end else begin
								st.partner = src;
								r.tx_kind = TxPairEcho;
								if (it.echo_send_ok) begin
									go_synced(st, r);
									r.save_request = 1'b1;
									paired_now = 1'b1;
								end
							end
						end
						if (!st.radio_live && !paired_now) begin
							set_radio(st, r, RadioDirect);
						end
						// timeout is checked even after a pair in the same tick
						if (st.retry > c.pair_timeout_ticks) begin
							st.mode = MODE_BLANK;
							go_halt(st, r);
						end
					end
					MODE_SYNCING: if (c.role_leader) begin
						if (st.mb_full) begin
							st.mb_full = 1'b0;
							if (st.mb_kind != KindSyncEcho || src != st.partner) begin
								r.protocol_error = 1'b1;
							end else begin
								go_synced(st, r);
							end
						end else if (st.retry > c.leader_sync_timeout_ticks) begin
							st.mode = MODE_UNSYNCED;
							go_halt(st, r);
						end else if (st.retry % ResendTicks == 0) begin
							r.tx_kind = TxSyncReq;
						end
					end else begin
						if (st.mb_full) begin
							st.mb_full = 1'b0;
							if (st.mb_kind != KindSyncReq || src != st.partner) begin
								r.protocol_error = 1'b1;
							end else begin
								r.tx_kind = TxSyncEcho;
								if (it.echo_send_ok) begin
									go_synced(st, r);
								end
							end
						end
						if (st.retry > c.follower_sync_timeout_ticks) begin
							st.mode = MODE_UNSYNCED;
							go_halt(st, r);
						end
					end
					default: ;
				endcase
			end
		end
		r.mode = st.mode;
		r.in_sync = st.synced;
		r.partner_address = st.partner;
		return r;
	endfunction

	function automatic logic [AddrBits-1:0] rand_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic item_t mk_item(input bit pressed, input logic [15:0] len, input bit arrived,
		input logic [2:0] kind, input logic [AddrBits-1:0] src, input bit ok);
		item_t it;
		it.button_pressed = pressed;
		it.press_ms = len;
		it.msg_arrived = arrived;
		it.msg_kind = kind;
		it.msg_source = src;
		it.echo_send_ok = ok;
		return it;
	endfunction

	function automatic item_t rand_item();
		logic [15:0] len;
		logic [2:0] kind;
		case ($urandom_range(0, 3))
			0: len = cfg_now.long_press_ms + 16'd1;
			1: len = cfg_now.very_long_press_ms;
			default: len = 16'($urandom);
		endcase
		kind = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(KindOther + 1, KindMax)) :
			3'($urandom_range(KindPairReq, KindOther));
		return mk_item($urandom_range(0, 3) == 0, len, $urandom_range(0, 1), kind, rand_addr(),
			$urandom_range(0, 1));
	endfunction

	// Queue a request. When guarded, requests that would end the link (halt or the
	// terminal synced mode) are swapped for other random ones, finally a quiet one.
	task automatic push_item(input item_t it, input bit guarded);
		link_state_t trial;
		for (int n = 0; n < 8; n++) begin
			trial = plan_state;
			void'(step_link(trial, cfg_now, it));
			if (!guarded || !(trial.halted || trial.mode == MODE_SYNCED) || n == 7) begin
				break;
			end
			it = rand_item();
			if (n >= 5) begin
				it.button_pressed = 1'b0;
				it.msg_arrived = 1'b0;
				it.echo_send_ok = 1'b0;
			end
		end
		plan_state = trial;
		ticks_queued.push_back(it);
	endtask

	task automatic wait_idle();
		while (ticks_queued.size() != 0 || s_tvalid || due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegRoleLeader: cfg_now.role_leader = val[0];
			RegLongPress:  cfg_now.long_press_ms = val;
			RegVLongPress: cfg_now.very_long_press_ms = val;
			RegPairTo:     cfg_now.pair_timeout_ticks = val;
			RegLSyncTo:    cfg_now.leader_sync_timeout_ticks = val;
			RegFSyncTo:    cfg_now.follower_sync_timeout_ticks = val;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, want);
		errors++;
	endtask

	// request driver and result-side stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (s_gap != 0) begin
					s_gap <= s_gap - 1;
					s_tvalid <= 1'b0;
				end else if (ticks_queued.size() != 0) begin
					cur_item <= ticks_queued.pop_front();
					s_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0) begin
						s_gap <= $urandom_range(1, 16);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (m_gap != 0) begin
				m_gap <= m_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0) begin
					m_gap <= $urandom_range(1, 16);
				end
			end
		end
	end

	// accept, predict, check, watchdog
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				due_results.push_back(step_link(link_state, cfg_now, cur_item));
			end
			if (m_tvalid && m_tready) begin
				seen.mode = m_tdata[2:0];
				seen.in_sync = m_tdata[3];
				seen.partner_address = m_tdata[51:4];
				seen.tx_kind = m_tdata[54:52];
				seen.radio_cmd = m_tdata[56:55];
				seen.sync_mark = m_tdata[57];
				seen.save_request = m_tdata[58];
				seen.shutdown_request = m_tdata[59];
				seen.protocol_error = m_tdata[60];
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = due_results.pop_front();
					if (seen.mode !== want.mode)
						report_mismatch("mode", 64'(seen.mode), 64'(want.mode));
					if (seen.in_sync !== want.in_sync)
						report_mismatch("in_sync", 64'(seen.in_sync), 64'(want.in_sync));
					if (seen.partner_address !== want.partner_address)
						report_mismatch("partner_address", 64'(seen.partner_address),
							64'(want.partner_address));
					if (seen.tx_kind !== want.tx_kind)
						report_mismatch("tx_kind", 64'(seen.tx_kind), 64'(want.tx_kind));
					if (seen.radio_cmd !== want.radio_cmd)
						report_mismatch("radio_cmd", 64'(seen.radio_cmd), 64'(want.radio_cmd));
					if (seen.sync_mark !== want.sync_mark)
						report_mismatch("sync_mark", 64'(seen.sync_mark), 64'(want.sync_mark));
					if (seen.save_request !== want.save_request)
						report_mismatch("save_request", 64'(seen.save_request),
							64'(want.save_request));
					if (seen.shutdown_request !== want.shutdown_request)
						report_mismatch("shutdown_request", 64'(seen.shutdown_request),
							64'(want.shutdown_request));
					if (seen.protocol_error !== want.protocol_error)
						report_mismatch("protocol_error", 64'(seen.protocol_error),
							64'(want.protocol_error));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_ticks <= 0;
			end else begin
				idle_ticks <= idle_ticks + 1;
			end
			if (idle_ticks >= StallLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int ending;
		int sat_ticks;
		logic [15:0] lim;
		plan_state = reset_state();
		link_state = reset_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: follower first, every register written
		write_reg(RegRoleLeader, 16'd0);
		write_reg(RegLongPress, 16'd100);
		write_reg(RegVLongPress, 16'hFFFF);
		write_reg(RegPairTo, 16'hFFFE);
		write_reg(RegLSyncTo, 16'd1);
		write_reg(RegFSyncTo, 16'hFFFE);
		// message held in blank, the next one is dropped on the full mailbox
		push_item(mk_item(0, 16'd0, 1, KindPairReq, '1, 0), 1'b1);
		push_item(mk_item(0, 16'hFFFF, 1, KindSyncReq, '0, 0), 1'b1);
		// long presses outside syncing are ignored
		push_item(mk_item(1, 16'd101, 0, KindPairEcho, rand_addr(), 1), 1'b1);
		push_item(mk_item(1, 16'hFFFF, 1, KindPairEcho, rand_addr(), 1), 1'b1);
		push_item(mk_item(0, 16'd0, 1, KindSyncReq, rand_addr(), 1), 1'b1);
		push_item(mk_item(0, 16'd0, 1, KindSyncEcho, rand_addr(), 1), 1'b1);
		for (int k = KindOther; k <= KindMax; k++) begin
			push_item(mk_item(0, 16'($urandom), 1, 3'(k), rand_addr(), $urandom_range(0, 1)), 1'b1);
		end
		push_item(mk_item(0, 16'($urandom), 1, KindPairReq, '0, 0), 1'b1);
		wait_idle();
		write_reg(RegRoleLeader, 16'd1);
		push_item(mk_item(0, 16'd0, 1, KindPairReq, rand_addr(), 1), 1'b1);
		push_item(mk_item(0, 16'd0, 1, KindSyncReq, rand_addr(), 0), 1'b1);
		push_item(mk_item(0, 16'd0, 1, KindSyncEcho, rand_addr(), 1), 1'b1);
		push_item(mk_item(0, 16'd0, 1, KindOther, rand_addr(), 0), 1'b1);
		push_item(mk_item(0, 16'd0, 1, KindMax, rand_addr(), 1), 1'b1);

		// random phases, both roles, threshold extremes
		for (int p = 0; p < RandomPhases; p++) begin
			wait_idle();
			idle_on = (p != 3);
			write_reg(RegRoleLeader, 16'(p % 2));
			lim = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF : 16'($urandom);
			write_reg(RegLongPress, lim);
			write_reg(RegVLongPress, (p == 0) ? 16'hFFFF : (p == 1) ? 16'd0 :
				16'($urandom_range(lim, 16'hFFFF)));
			write_reg(RegPairTo, 16'($urandom_range(plan_state.retry + 400, 16'hFFFE)));
			write_reg(RegLSyncTo, (p == 0) ? 16'd1 : (p == 1) ? 16'hFFFE : 16'($urandom_range(1, 16'hFFFE)));
			write_reg(RegFSyncTo, (p == 0) ? 16'hFFFE : (p == 1) ? 16'd1 : 16'($urandom_range(1, 16'hFFFE)));
			repeat (PhaseTicks) push_item(rand_item(), 1'b1);
		end

		// all-ones pair timeout; no idling from here on
		wait_idle();
		idle_on = 1'b0;
		write_reg(RegPairTo, 16'hFFFF);
		sat_ticks = 40;
		repeat (sat_ticks) push_item(rand_item(), 1'b1);

		// one way out of the link, then a few ticks while halted
		wait_idle();
		ending = $urandom_range(0, 4);
		case (ending)
			0: begin
				write_reg(RegPairTo, 16'd1);
				push_item(mk_item(0, 16'($urandom), 0, KindPairReq, rand_addr(), 0), 1'b0);
			end
			1: begin
				lim = 16'($urandom_range(0, 16'hFFFE));
				write_reg(RegVLongPress, lim);
				push_item(mk_item(1, lim + 16'd1, 1, KindPairEcho, rand_addr(), 1), 1'b0);
			end
			2: begin
				lim = 16'($urandom);
				write_reg(RegLongPress, lim);
				write_reg(RegVLongPress, 16'hFFFF);
				push_item(mk_item(1, 16'($urandom_range(0, lim)), 0, KindSyncReq, rand_addr(), 0), 1'b0);
			end
			3: begin
				write_reg(RegLongPress, 16'd100);
				write_reg(RegVLongPress, 16'hFFFF);
				write_reg(RegRoleLeader, 16'($urandom_range(0, 1)));
				push_item(mk_item(0, 16'd0, 1, cfg_now.role_leader ? KindPairEcho : KindPairReq,
					rand_addr(), 1), 1'b0);
				// synced holds its mailbox; later messages are dropped
				repeat (3) push_item(mk_item(0, 16'($urandom), 1, 3'($urandom), rand_addr(),
					$urandom_range(0, 1)), 1'b0);
				push_item(mk_item(1, 16'd1000, 0, KindPairReq, rand_addr(), 0), 1'b0);
			end
			default: begin
				// follower pairs and times out on the same tick
				write_reg(RegRoleLeader, 16'd0);
				write_reg(RegPairTo, 16'd1);
				push_item(mk_item(0, 16'd0, 1, KindPairReq, rand_addr(), 1), 1'b0);
			end
		endcase
		repeat (16) push_item(rand_item(), 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		if (due_results.size() != 0) begin
			report_mismatch("missing results", 64'(due_results.size()), '0);
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
